### design/plsl_pkg.sv
// Package for the piecewise linear segment lookup core.
// Holds action and status codes, the segment record and the controller/datapath
// command and status structs. No dependencies.
package plsl_pkg;

   // Action codes of a request word
   localparam logic [1:0] ACT_QUERY = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Status codes of a response word
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_MATCH = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_DROPPED  = 2'd3;

   // Default height after reset, integer part (scaled by the fraction width)
   localparam logic [63:0] DFLT_HEIGHT_INT = 64'd370;

   // One stored segment
   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [7:0]         kind;
   } seg_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_RCHK,
      S_SCAN,
      S_DIV,
      S_MUL,
      S_ADD,
      S_PUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // request word taken this cycle
      logic scan_step;  // issue next table read of the scan
      logic capture;    // matched entry sits in the read register
      logic rec_upd;    // remember the scan hit as the recent segment
      logic no_match;   // scan ran out
      logic mul_go;     // form slope product
      logic fin;        // form final height
      logic put;        // move result into output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_zero;
      logic recent_ok;
      logic hit;
      logic chk_vld;
      logic last;
      logic div_done;
      logic rsp_free;
   } sts_type;

endpackage

### design/plsl_chan_if.sv
// Handshake channels of the segment lookup core: request and response words.
// Depends on plsl_pkg.
interface plsl_req_if
   import plsl_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] position;
   logic signed [31:0] seg_start_x;
   logic signed [31:0] seg_start_y;
   logic signed [31:0] seg_end_x;
   logic signed [31:0] seg_end_y;
   logic [7:0]         seg_kind;

   modport source (output valid, action, position, seg_start_x, seg_start_y,
                   seg_end_x, seg_end_y, seg_kind, input ready);
   modport sink   (input valid, action, position, seg_start_x, seg_start_y,
                   seg_end_x, seg_end_y, seg_kind, output ready);
endinterface

interface plsl_rsp_if
   import plsl_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic signed [31:0] height;
   logic [7:0]         kind;
   logic [1:0]         status;

   modport source (output valid, height, kind, status, input ready);
   modport sink   (input valid, height, kind, status, output ready);
endinterface

### design/plsl_div.sv
// Restoring divider for the interpolation factor (off << FRAC_BITS) / dx,
// with off <= dx, one quotient bit per cycle. Depends on plsl_pkg.
module plsl_div
   import plsl_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          dividend,
   input  logic [31:0]          divisor,
   output logic [FRAC_BITS:0]   quot,
   output logic                 done
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [32:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic [FRAC_BITS:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge;
   logic [32:0]          diff;

   // one compare/subtract step
   always_comb begin
      ge      = rem_ff >= {1'b0, dvs_ff};
      diff    = ge ? (rem_ff - {1'b0, dvs_ff}) : rem_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {diff[31:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-1:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

### design/plsl_ctrl.sv
// Controller of the segment lookup core: sequences recent check, table scan,
// division, multiply and result hand-off. Depends on plsl_pkg.
module plsl_ctrl
   import plsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   input  sts_type    sts,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action == ACT_QUERY && !sts.count_zero) begin
                  state_in = sts.recent_ok ? S_RCHK : S_SCAN;
               end else begin
                  state_in = S_PUT;
               end
            end
         end
         S_RCHK: begin
            if (sts.hit) begin
               cmd.capture = 1'b1;
               state_in    = S_DIV;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.chk_vld && sts.hit) begin
               cmd.capture = 1'b1;
               cmd.rec_upd = 1'b1;
               state_in    = S_DIV;
            end else if (sts.chk_vld && sts.last) begin
               cmd.no_match = 1'b1;
               state_in     = S_PUT;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.fin  = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            if (sts.rsp_free) begin
               cmd.put  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/plsl_dpath.sv
// Datapath of the segment lookup core: segment memory, count and recent
// pointer, scan pipeline, divider, multiplier and output register.
// Depends on plsl_pkg and plsl_div.
module plsl_dpath
   import plsl_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_seg_start_x,
   input  logic signed [31:0] req_seg_start_y,
   input  logic signed [31:0] req_seg_end_x,
   input  logic signed [31:0] req_seg_end_y,
   input  logic [7:0]         req_seg_kind,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_height,
   output logic [7:0]         rsp_kind,
   output logic [1:0]         rsp_status
);

   localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int PROD_W = FRAC_BITS + 35;
   localparam logic [63:0] DFLT_WIDE = DFLT_HEIGHT_INT << FRAC_BITS;

   // segment memory
   seg_type seg_mem [MAX_SEGMENTS];
   seg_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   seg_type          wr_data;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             recent_vld_ff, recent_vld_in;
   logic [IDX_W-1:0] recent_ff, recent_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             chk_vld_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [31:0]      dflt_ff;

   // payload
   logic signed [31:0] pos_ff;
   logic signed [31:0] sy_ff;
   logic signed [32:0] dy_ff;
   logic               dxz_ff;
   logic [7:0]         kind_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [31:0]        res_height_ff, res_height_in;
   logic [7:0]         res_kind_ff, res_kind_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [31:0]        rsp_height_ff;
   logic [7:0]         rsp_kind_ff;
   logic [1:0]         rsp_status_ff;

   logic               count_full;
   logic               holds;
   logic signed [32:0] dx_wide;
   logic signed [32:0] off_wide;
   logic signed [32:0] dy_wide;
   logic [FRAC_BITS:0] quot;
   logic [FRAC_BITS:0] fact;
   logic               div_done;
   logic signed [PROD_W-1:0] delta;

   assign count_full = count_ff >= CNT_W'(MAX_SEGMENTS);

   // table write on an accepted load with room
   assign mem_we  = cmd.accept && (req_action == ACT_LOAD) && !count_full;
   assign wr_data = '{start_x: req_seg_start_x, start_y: req_seg_start_y,
                      end_x: req_seg_end_x, end_y: req_seg_end_y, kind: req_seg_kind};
   assign rd_addr = cmd.scan_step ? scan_ff : recent_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= seg_mem[rd_addr];
   end

   // span check and interpolation operands of the entry in the read register
   assign holds    = (rd_data_ff.start_x <= pos_ff) && (pos_ff <= rd_data_ff.end_x);
   assign dx_wide  = 33'(rd_data_ff.end_x) - 33'(rd_data_ff.start_x);
   assign off_wide = 33'(pos_ff) - 33'(rd_data_ff.start_x);
   assign dy_wide  = 33'(rd_data_ff.end_y) - 33'(rd_data_ff.start_y);

   // count and recent segment
   always_comb begin
      count_in      = count_ff;
      recent_vld_in = recent_vld_ff;
      recent_in     = recent_ff;
      if (mem_we) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.accept && req_action == ACT_CLEAR) begin
         count_in      = '0;
         recent_vld_in = 1'b0;
         recent_in     = '0;
      end
      if (cmd.rec_upd) begin
         recent_vld_in = 1'b1;
         recent_in     = chk_idx_ff;
      end
   end

   assign scan_in = cmd.scan_step ? scan_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         recent_vld_ff <= 1'b0;
         recent_ff     <= '0;
         scan_ff       <= '0;
         chk_vld_ff    <= 1'b0;
         dflt_ff       <= DFLT_WIDE[31:0];
      end else begin
         count_ff      <= count_in;
         recent_vld_ff <= recent_vld_in;
         recent_ff     <= recent_in;
         scan_ff       <= scan_in;
         chk_vld_ff    <= cmd.scan_step;
         if (csr_wr_en) begin
            dflt_ff <= csr_wr_data;
         end
      end
      chk_idx_ff <= scan_ff;
   end

   // query position and matched segment operands
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff <= req_position;
      end
      if (cmd.capture) begin
         sy_ff   <= rd_data_ff.start_y;
         dy_ff   <= dy_wide;
         dxz_ff  <= (dx_wide == '0);
         kind_ff <= rd_data_ff.kind;
      end
   end

   plsl_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.capture),
      .dividend (off_wide[31:0]),
      .divisor  (dx_wide[31:0]),
      .quot     (quot),
      .done     (div_done)
   );

   // zero-width segment gives its start height
   assign fact  = dxz_ff ? '0 : quot;
   assign delta = prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         prod_ff <= dy_ff * $signed({1'b0, fact});
      end
   end

   // result word waiting for the output register
   always_comb begin
      res_height_in = res_height_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         res_height_in = '0;
         res_kind_in   = '0;
         res_status_in = STAT_OK;
         if (req_action == ACT_QUERY && count_ff == '0) begin
            res_height_in = dflt_ff;
            res_status_in = STAT_EMPTY;
         end else if (req_action == ACT_LOAD && count_full) begin
            res_status_in = STAT_DROPPED;
         end
      end else if (cmd.no_match) begin
         res_status_in = STAT_NO_MATCH;
      end else if (cmd.fin) begin
         res_height_in = sy_ff + delta[31:0];
         res_kind_in   = kind_ff;
         res_status_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      res_height_ff <= res_height_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
   end

   // output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (cmd.put) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (cmd.put) begin
         rsp_height_ff <= res_height_ff;
         rsp_kind_ff   <= res_kind_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;

   // status to controller
   always_comb begin
      sts            = '0;
      sts.count_zero = (count_ff == '0);
      sts.recent_ok  = recent_vld_ff && (CNT_W'(recent_ff) < count_ff);
      sts.hit        = holds;
      sts.chk_vld    = chk_vld_ff;
      sts.last       = (chk_idx_ff == IDX_W'(count_ff - 1'b1));
      sts.div_done   = div_done;
      sts.rsp_free   = !rsp_vld_ff || rsp_ready;
   end

endmodule

### design/piecewise_linear_segment_lookup_core.sv
// Top level of the piecewise linear segment lookup core.
// Depends on plsl_pkg, plsl_chan_if, plsl_ctrl and plsl_dpath.
//
//   channel   direction  handshake        word
//   req_chan  in         valid / ready    action, position, segment fields
//   rsp_chan  out        valid / ready    height, kind, status
//   csr_*     in         write enable     default_height
//
// Load, clear and empty-table queries go straight to the result hand-off. A
// query tries the recent segment first when it holds a valid entry, else or
// after a miss scans the table one entry per cycle, set by the single memory
// read port; a match is then divided, multiplied and added. A query with no
// match scans every stored entry before its result is handed off.
// The quotient comes from a one-bit-per-cycle divider (FRAC_BITS + 1 steps).
// Reset is synchronous; the table needs no clearing pass. A result waiting on
// rsp_chan does not stop the next word from being taken and worked on.
module piecewise_linear_segment_lookup_core
   import plsl_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   plsl_req_if.sink    req_chan,
   plsl_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   plsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .sts        (sts),
      .req_ready  (req_chan.ready),
      .cmd        (cmd)
   );

   plsl_dpath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_chan.action),
      .req_position    (req_chan.position),
      .req_seg_start_x (req_chan.seg_start_x),
      .req_seg_start_y (req_chan.seg_start_y),
      .req_seg_end_x   (req_chan.seg_end_x),
      .req_seg_end_y   (req_chan.seg_end_y),
      .req_seg_kind    (req_chan.seg_kind),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_height      (rsp_chan.height),
      .rsp_kind        (rsp_chan.kind),
      .rsp_status      (rsp_chan.status)
   );

endmodule
